// ----- hw/rtl/summed_area_table_power_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the summed-area table block
// Shared check forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUMMED_AREA_TABLE_POWER_TOP_DEFINES_SVH
`define SUMMED_AREA_TABLE_POWER_TOP_DEFINES_SVH

// condition holds at every edge
`define SAT_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SAT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SAT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/sat_pkg.sv -----
// ----------------------------------------------------------------------------
// sat_pkg
// Types, constants and helper functions of the summed-area table block.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int SUM_W          = 64;
	localparam int GEOM_W         = 11;
	localparam int EXP_W          = 3;
	localparam int APB_ADDR_W     = 4;
	localparam int APB_DATA_W     = 32;
	localparam int MAX_EXP        = 4;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 12;

	localparam logic [GEOM_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
	localparam logic [GEOM_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
	localparam logic [EXP_W-1:0]  RST_EXPONENT     = 3'd1;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_EXPONENT     = 2'd2;

	typedef struct packed {
		logic [GEOM_W-1:0] image_width;
		logic [GEOM_W-1:0] image_height;
		logic [EXP_W-1:0]  exponent;
	} sat_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POW,
		ST_ROW,
		ST_AREA
	} sat_state_t;

	typedef struct packed {
		logic load;     // beat accepted: latch pixel, issue line store read
		logic mul;      // one multiply step of the power
		logic row_add;  // add powered pixel into the row sum
		logic commit;   // form area sum, write line store, load output
	} sat_cmd_t;

	typedef struct packed {
		logic out_busy; // output register holds a beat that is not taken
	} sat_sts_t;

	// exponent with out-of-range codes folded onto 1..4
	function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] ex);
		logic [EXP_W-1:0] r;
		if (ex == '0)
			r = EXP_W'(1);
		else if (ex > EXP_W'(MAX_EXP))
			r = EXP_W'(MAX_EXP);
		else
			r = ex;
		return r;
	endfunction

	// clamp a sign-extended 65-bit sum to the signed 64-bit range
	function automatic logic [SUM_W-1:0] sat65(input logic [SUM_W:0] s);
		logic [SUM_W-1:0] r;
		if (s[SUM_W] != s[SUM_W-1])
			r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			r = s[SUM_W-1:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/sat_cfg.sv -----
// ----------------------------------------------------------------------------
// sat_cfg
// APB register file: image width, image height and exponent.
// ----------------------------------------------------------------------------
module sat_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sat_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sat_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sat_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output sat_pkg::sat_cfg_t                cfg
);
	import sat_pkg::*;

	sat_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.exponent     <= RST_EXPONENT;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[GEOM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[GEOM_W-1:0];
				REG_EXPONENT:     cfg_q.exponent     <= pwdata[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_q.image_width);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_q.image_height);
			REG_EXPONENT:     prdata = APB_DATA_W'(cfg_q.exponent);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/sat_ctrl.sv -----
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer: accept, power steps, row add, area commit.
// ----------------------------------------------------------------------------
module sat_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [sat_pkg::EXP_W-1:0]  exponent,
	input  sat_pkg::sat_sts_t          sts,
	output sat_pkg::sat_cmd_t          cmd
);
	import sat_pkg::*;

	sat_state_t       state_q;
	sat_state_t       state_d;
	logic [1:0]       steps;
	logic [1:0]       cnt_q;

	// multiplies needed: exponent - 1
	assign steps = 2'(clamp_exp(exponent) - EXP_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid)
					state_d = (steps != '0) ? ST_POW : ST_ROW;
			end
			ST_POW: begin
				if (cnt_q == 2'd1)
					state_d = ST_ROW;
			end
			ST_ROW:  state_d = ST_AREA;
			ST_AREA: begin
				if (!sts.out_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load      = s_axis_tvalid;
			end
			ST_POW:  cmd.mul     = 1'b1;
			ST_ROW:  cmd.row_add = 1'b1;
			ST_AREA: cmd.commit  = !sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				cnt_q <= steps;
			else if (cmd.mul)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ----- hw/rtl/sat_dp.sv -----
// ----------------------------------------------------------------------------
// sat_dp
// Datapath: power unit, row sum, line store, counters and output register.
// ----------------------------------------------------------------------------
`include "summed_area_table_power_top_defines.svh"

module sat_dp #(
	parameter int MAX_WIDTH  = sat_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sat_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = sat_pkg::DEF_PIXEL_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sat_pkg::sat_cfg_t           cfg,
	input  sat_pkg::sat_cmd_t           cmd,
	output sat_pkg::sat_sts_t           sts,
	input  logic [PIXEL_BITS-1:0]       pixel,
	input  logic                        start_of_frame,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [sat_pkg::SUM_W-1:0]   area_sum,
	output logic                        end_of_row,
	output logic                        end_of_frame
);
	import sat_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW = 4 * PIXEL_BITS;

	// line store of the previous row's area sums
	logic [SUM_W-1:0]      mem [MAX_WIDTH];
	logic [SUM_W-1:0]      rd_q;
	logic [CW-1:0]         rd_addr;

	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [SUM_W-1:0]      row_sum_q;

	logic [PIXEL_BITS-1:0] mag_q;
	logic                  sub_q;
	logic [PW-1:0]         p_q;
	logic [PW+PIXEL_BITS-1:0] prod;

	logic                  pix_neg;
	logic [PIXEL_BITS-1:0] pix_mag;
	logic [EXP_W-1:0]      ex_c;

	logic [31:0]           w32;
	logic [31:0]           h32;
	logic [31:0]           w_last32;
	logic [31:0]           h_last32;
	logic [CW-1:0]         w_last;
	logic [RW-1:0]         h_last;
	logic                  eor;
	logic                  eof;

	logic [SUM_W:0]        p_ext;
	logic [SUM_W:0]        row_s;
	logic [SUM_W-1:0]      above;
	logic [SUM_W:0]        area_s;
	logic [SUM_W-1:0]      area;

	logic                  out_valid_q;
	logic [SUM_W-1:0]      out_area_q;
	logic                  out_eor_q;
	logic                  out_eof_q;

	assign pix_neg = pixel[PIXEL_BITS-1];
	assign pix_mag = pix_neg ? (~pixel + PIXEL_BITS'(1)) : pixel;
	assign ex_c    = clamp_exp(cfg.exponent);

	// clamp geometry onto 1..MAX and form the last index
	assign w32      = 32'(cfg.image_width);
	assign h32      = 32'(cfg.image_height);
	assign w_last32 = (w32 == '0) ? '0 :
		(w32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH - 1) : w32 - 32'd1;
	assign h_last32 = (h32 == '0) ? '0 :
		(h32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT - 1) : h32 - 32'd1;
	assign w_last   = w_last32[CW-1:0];
	assign h_last   = h_last32[RW-1:0];

	assign eor = (col_q >= w_last);
	assign eof = eor && (row_q >= h_last);

	assign rd_addr = start_of_frame ? '0 : col_q;

	assign prod   = p_q * mag_q;
	assign p_ext  = {{(SUM_W+1-PW){1'b0}}, p_q};
	assign row_s  = sub_q ? ({row_sum_q[SUM_W-1], row_sum_q} - p_ext)
		: ({row_sum_q[SUM_W-1], row_sum_q} + p_ext);
	assign above  = (row_q == '0) ? '0 : rd_q;
	assign area_s = {row_sum_q[SUM_W-1], row_sum_q} + {above[SUM_W-1], above};
	assign area   = sat65(area_s);

	always_ff @(posedge clk) begin
		if (cmd.load)
			rd_q <= mem[rd_addr];
		if (cmd.commit)
			mem[col_q] <= area;
	end

	// power unit: one multiply per step, negated at the row add for odd powers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= pix_mag;
			sub_q <= pix_neg & ex_c[0];
			p_q   <= PW'(pix_mag);
		end else if (cmd.mul) begin
			p_q <= prod[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (cmd.load && start_of_frame) begin
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (cmd.row_add) begin
			row_sum_q <= sat65(row_s);
		end else if (cmd.commit) begin
			if (eor) begin
				col_q     <= '0;
				row_sum_q <= '0;
				row_q     <= eof ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_area_q <= area;
			out_eor_q  <= eor;
			out_eof_q  <= eof;
		end
	end

	assign sts.out_busy  = out_valid_q & ~m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign area_sum      = out_area_q;
	assign end_of_row    = out_eor_q;
	assign end_of_frame  = out_eof_q;

	`SAT_ASSERT_NOW(a_one_cmd, $countones(cmd) <= 1, "more than one datapath command")
	`SAT_ASSERT_IMP(a_commit_slot, cmd.commit, !(out_valid_q && !m_axis_tready),
		"result committed over an untaken beat")
	`SAT_ASSERT_IMP(a_eof_in_row, out_valid_q && out_eof_q, out_eor_q,
		"frame end without row end")
	`SAT_ASSERT_NXT(a_col_wrap, cmd.commit && eor, col_q == '0,
		"column did not wrap at row end")

endmodule

// ----- hw/rtl/summed_area_table_power_top.sv -----
// ----------------------------------------------------------------------------
// summed_area_table_power_top
// Summed-area table of powered pixels, APB configured, stream in and out.
// ----------------------------------------------------------------------------
// Each pixel is accepted in ST_IDLE, then its power is formed by repeated steps
// through a single multiplier in ST_POW (exponent - 1 multiplies), then ST_ROW
// does the saturating row add and ST_AREA the saturating area add and line
// store write. The next beat is taken in the cycle right after the area step,
// so a new pixel is accepted only once the previous one has been committed. A
// result waiting in the output register does not block the next accept by
// itself; it only holds the area step, which in turn holds the input. The line
// store is not cleared after reset and needs no clearing pass: the first row
// after reset or after a start-of-frame beat never reads it, and later rows
// read only entries that earlier rows have written.
module summed_area_table_power_top #(
	parameter int MAX_WIDTH  = sat_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sat_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = sat_pkg::DEF_PIXEL_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [sat_pkg::APB_ADDR_W-1:0]         paddr,
	input  logic [sat_pkg::APB_DATA_W-1:0]         pwdata,
	output logic [sat_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_axis_tdata,  // pixel, zero pad
	input  logic                                   s_axis_tuser,  // start_of_frame
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [sat_pkg::SUM_W-1:0]              m_axis_tdata,  // area_sum
	output logic                                   m_axis_tlast,  // end_of_row
	output logic                                   m_axis_tuser   // end_of_frame
);
	import sat_pkg::*;

	sat_cfg_t cfg;
	sat_cmd_t cmd;
	sat_sts_t sts;

	sat_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sat_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.exponent      (cfg.exponent),
		.sts           (sts),
		.cmd           (cmd)
	);

	sat_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.pixel          (s_axis_tdata[PIXEL_BITS-1:0]),
		.start_of_frame (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.area_sum       (m_axis_tdata),
		.end_of_row     (m_axis_tlast),
		.end_of_frame   (m_axis_tuser)
	);

endmodule
